### sv/pacmd_pkg.sv
// Shared types and constants of the pileup allele counter.
package pacmd_pkg;

  localparam int KEY_W = 64;
  localparam int POS_W = 31;
  localparam int QUAL_W = 8;
  localparam int COUNT_W = 32;
  localparam int STATUS_W = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 31;
  localparam int CAP_W = 9;
  localparam int EPOCH_W = 8;
  localparam int MOD_BITS = 8;
  localparam int MOD_CYC_W = $clog2(KEY_W / MOD_BITS);

  localparam logic [QUAL_W-1:0] QUAL_MISSING = 8'hff;

  localparam logic [STATUS_W-1:0] ST_OK = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_ARG = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_PILEUP = 3'd2;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_ALLELE_A = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALLELE_B = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_QUAL = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OVERLAP = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SITE_POS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ENTRIES = 3'd5;

  typedef struct packed {
    logic              is_gap;
    logic              record_ok;
    logic [3:0]        base_code;
    logic [QUAL_W-1:0] base_quality;
    logic              secondary_read;
    logic              same_contig;
    logic [POS_W-1:0]  read_start;
    logic [POS_W-1:0]  read_end;
    logic [POS_W-1:0]  mate_start;
    logic [KEY_W-1:0]  name_key;
    logic              last_of_site;
  } in_item_t;

  typedef struct packed {
    logic [COUNT_W-1:0]  count_a;
    logic [COUNT_W-1:0]  count_b;
    logic [COUNT_W-1:0]  count_other;
    logic [STATUS_W-1:0] status;
  } out_item_t;

endpackage

### sv/pileup_allele_counter_mate_dedup_unit.sv
// Top level of the pileup allele counter with overlapping-mate suppression.
//
//   Channel  Direction  Handshake            Payload
//   cfg      in         cfg_we               cfg_index, cfg_wdata
//   in       in         in_valid / in_ready  in_data (in_item_t)
//   out      out        out_valid/out_ready  out_data (out_item_t)
//
// An item without a name-set lookup goes from idle through evaluation and, if it is counted,
// the counting state to the result state. A lookup adds a key reduction and a read and check
// per probed slot, and each occupied slot scanned by a backward-shift removal costs a read and
// a reduction of its home; the single read port and the shared reduction unit set these costs.
// After reset, and after every 255th closed site, a clearing pass writes all 2*MAX_ENTRIES+1
// slots of the slot memory, during which no transaction is accepted on the input.
// A finished result waits in the output register, and the next input transaction is taken
// while it waits; a new result stalls only if the previous one has not been taken.
module pileup_allele_counter_mate_dedup_unit
  import pacmd_pkg::*;
#(
  parameter int MAX_ENTRIES = 128
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data
);

  localparam int SLOTS = 2 * MAX_ENTRIES + 1;
  localparam int AW = $clog2(SLOTS);
  localparam int IDX_W = (AW > CAP_W) ? AW : CAP_W;
  localparam int WORD_W = EPOCH_W + KEY_W;

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_EVAL  = 4'd2;
  localparam logic [3:0] S_HOME  = 4'd3;
  localparam logic [3:0] S_FRD   = 4'd4;
  localparam logic [3:0] S_FCHK  = 4'd5;
  localparam logic [3:0] S_RNEXT = 4'd6;
  localparam logic [3:0] S_RCHK  = 4'd7;
  localparam logic [3:0] S_RMOD  = 4'd8;
  localparam logic [3:0] S_RFIN  = 4'd9;
  localparam logic [3:0] S_COUNT = 4'd10;
  localparam logic [3:0] S_POST  = 4'd11;

  // Configuration registers.
  logic [1:0]        allele_lo;
  logic [1:0]        allele_hi;
  logic [QUAL_W-1:0] min_qual;
  logic              overlap;
  logic [POS_W-1:0]  site_pos;
  logic [7:0]        name_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      allele_lo  <= 2'd0;
      allele_hi  <= 2'd1;
      min_qual   <= '0;
      overlap    <= 1'b0;
      site_pos   <= '0;
      name_limit <= 8'd128;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ALLELE_A:    allele_lo  <= cfg_wdata[1:0];
        REG_ALLELE_B:    allele_hi  <= cfg_wdata[1:0];
        REG_MIN_QUAL:    min_qual   <= cfg_wdata[QUAL_W-1:0];
        REG_OVERLAP:     overlap    <= cfg_wdata[0];
        REG_SITE_POS:    site_pos   <= cfg_wdata[POS_W-1:0];
        REG_MAX_ENTRIES: name_limit <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // Control and working registers.
  logic [3:0]          state;
  in_item_t            item;
  logic [STATUS_W-1:0] st;
  logic                drop;
  logic                error_seen;
  logic [EPOCH_W-1:0]  epoch;
  logic [AW-1:0]       clr_cnt;
  logic [IDX_W-1:0]    idx;
  logic [IDX_W:0]      steps;
  logic                free_ok;
  logic [IDX_W-1:0]    free_idx;
  logic [IDX_W-1:0]    hole;
  logic [IDX_W-1:0]    nxt;
  logic [KEY_W-1:0]    moved_key;
  logic [IDX_W:0]      names_held;
  logic [COUNT_W-1:0]  tally_a;
  logic [COUNT_W-1:0]  tally_b;
  logic [COUNT_W-1:0]  tally_other;

  // The name count is kept wide enough for every slot, so that a limit lowered in
  // the middle of a site still compares exactly.
  logic [IDX_W:0] held_limit;
  assign held_limit = (IDX_W + 1)'(name_limit);

  // Slot memory: each word holds a site epoch tag above the key. A slot is
  // occupied when its tag equals the current epoch; tag zero is never current.
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [WORD_W-1:0] ram_rdata;

  pacmd_ram #(.WIDTH(WORD_W), .DEPTH(SLOTS)) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  logic             rd_valid;
  logic [KEY_W-1:0] rd_key;
  assign rd_valid = (ram_rdata[WORD_W-1:KEY_W] == epoch);
  assign rd_key   = ram_rdata[KEY_W-1:0];

  // Set capacity, and the wrapped successors of the probe and scan positions.
  logic [IDX_W-1:0] cap;
  logic [IDX_W-1:0] idx_inc;
  logic [IDX_W-1:0] nxt_inc;
  assign cap     = IDX_W'({name_limit, 1'b1});
  assign idx_inc = (idx + 1'b1 == cap) ? '0 : idx + 1'b1;
  assign nxt_inc = (nxt + 1'b1 == cap) ? '0 : nxt + 1'b1;

  // Item classification.
  logic bad_arg;
  logic qual_pass;
  logic is_a;
  logic is_b;
  logic want_insert;
  assign bad_arg = (allele_lo >= allele_hi) ||
                   (overlap && (32'(name_limit) > 32'(MAX_ENTRIES)));
  assign qual_pass = (item.base_quality == QUAL_MISSING) ? (min_qual == '0)
                                                         : (item.base_quality >= min_qual);
  assign is_a = (item.base_code == (4'd1 << allele_lo));
  assign is_b = !is_a && (item.base_code == (4'd1 << allele_hi));
  assign want_insert = overlap && !item.secondary_read &&
                       (item.read_end > item.mate_start) &&
                       (item.mate_start <= site_pos) && item.same_contig &&
                       (item.read_start <= item.mate_start);

  // Key reduction unit, shared by the lookup and by the removal scan.
  logic             mod_start;
  logic [KEY_W-1:0] mod_key;
  logic             mod_done;
  logic [IDX_W-1:0] mod_rem;

  pacmd_mod #(.REM_W(IDX_W)) u_mod (
    .clk     (clk),
    .rst     (rst),
    .start   (mod_start),
    .key     (mod_key),
    .modulus (cap),
    .done    (mod_done),
    .rem     (mod_rem)
  );

  assign mod_start = (state == S_EVAL && !error_seen && !bad_arg && !item.is_gap &&
                      item.record_ok && overlap && item.same_contig) ||
                     (state == S_RCHK && rd_valid);
  assign mod_key = (state == S_RCHK) ? rd_key : item.name_key;

  // Probe distances of the hole and the scanned slot from the scanned key's home.
  logic [IDX_W-1:0] dist_hole;
  logic [IDX_W-1:0] dist_nxt;
  assign dist_hole = (hole >= mod_rem) ? hole - mod_rem : cap - mod_rem + hole;
  assign dist_nxt  = (nxt >= mod_rem) ? nxt - mod_rem : cap - mod_rem + nxt;

  logic emit;
  assign emit = !drop && (st != ST_OK || item.last_of_site);

  assign in_ready = (state == S_IDLE);

  // Memory port selection.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_cnt;
    ram_wdata = '0;
    ram_raddr = idx[AW-1:0];
    unique case (state)
      S_CLEAR: ram_we = 1'b1;
      S_RNEXT: ram_raddr = nxt_inc[AW-1:0];
      S_RMOD: begin
        ram_we    = mod_done && (dist_hole < dist_nxt);
        ram_waddr = hole[AW-1:0];
        ram_wdata = {epoch, moved_key};
      end
      S_RFIN: begin
        ram_we    = 1'b1;
        ram_waddr = hole[AW-1:0];
      end
      S_COUNT: begin
        ram_we    = qual_pass && want_insert && free_ok && names_held != held_limit &&
                    !(is_a ? tally_a == '1 : is_b ? tally_b == '1 : tally_other == '1);
        ram_waddr = free_idx[AW-1:0];
        ram_wdata = {epoch, item.name_key};
      end
      default: ;
    endcase
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_cnt     <= '0;
      epoch       <= EPOCH_W'(1);
      error_seen  <= 1'b0;
      names_held  <= '0;
      tally_a     <= '0;
      tally_b     <= '0;
      tally_other <= '0;
      out_valid   <= 1'b0;
    end else begin
      // A result loaded in this same cycle keeps the output valid.
      if (out_valid && out_ready && !(state == S_POST && emit)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == AW'(SLOTS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            item  <= in_data;
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          drop <= error_seen;
          st   <= ST_OK;
          if (error_seen || (!bad_arg && item.is_gap)) begin
            state <= S_POST;
          end else if (bad_arg) begin
            st    <= ST_BAD_ARG;
            state <= S_POST;
          end else if (!item.record_ok) begin
            st    <= ST_BAD_PILEUP;
            state <= S_POST;
          end else if (overlap && item.same_contig) begin
            state <= S_HOME;
          end else begin
            free_ok <= 1'b0;
            state   <= S_COUNT;
          end
        end
        S_HOME: begin
          if (mod_done) begin
            idx   <= mod_rem;
            steps <= '0;
            state <= S_FRD;
          end
        end
        S_FRD: begin
          if (steps == {1'b0, cap}) begin
            free_ok <= 1'b0;
            state   <= S_COUNT;
          end else begin
            state <= S_FCHK;
          end
        end
        S_FCHK: begin
          if (!rd_valid) begin
            free_ok  <= 1'b1;
            free_idx <= idx;
            state    <= S_COUNT;
          end else if (rd_key == item.name_key) begin
            hole  <= idx;
            nxt   <= idx;
            steps <= (IDX_W + 1)'(1);
            if (names_held != '0) begin
              names_held <= names_held - 1'b1;
            end
            state <= S_RNEXT;
          end else begin
            idx   <= idx_inc;
            steps <= steps + 1'b1;
            state <= S_FRD;
          end
        end
        S_RNEXT: begin
          if (steps >= {1'b0, cap}) begin
            state <= S_RFIN;
          end else begin
            nxt   <= nxt_inc;
            state <= S_RCHK;
          end
        end
        S_RCHK: begin
          moved_key <= rd_key;
          state     <= rd_valid ? S_RMOD : S_RFIN;
        end
        S_RMOD: begin
          if (mod_done) begin
            if (dist_hole < dist_nxt) begin
              hole <= nxt;
            end
            steps <= steps + 1'b1;
            state <= S_RNEXT;
          end
        end
        S_RFIN: begin
          st    <= ST_OK;
          state <= S_POST;
        end
        S_COUNT: begin
          state <= S_POST;
          if (qual_pass) begin
            priority if (is_a ? tally_a == '1 : is_b ? tally_b == '1 : tally_other == '1) begin
              st <= ST_OVERFLOW;
            end else begin
              if (is_a) begin
                tally_a <= tally_a + 1'b1;
              end else if (is_b) begin
                tally_b <= tally_b + 1'b1;
              end else begin
                tally_other <= tally_other + 1'b1;
              end
              if (want_insert) begin
                if (names_held == held_limit || !free_ok) begin
                  st <= ST_EXHAUSTED;
                end else begin
                  names_held <= names_held + 1'b1;
                end
              end
            end
          end
        end
        S_POST: begin
          if (!(emit && out_valid && !out_ready)) begin
            if (emit) begin
              out_valid <= 1'b1;
              if (st == ST_OK) begin
                out_data <= '{count_a: tally_a, count_b: tally_b,
                              count_other: tally_other, status: ST_OK};
              end else begin
                out_data <= '{count_a: '0, count_b: '0, count_other: '0, status: st};
              end
            end
            error_seen <= !item.last_of_site && (drop || st != ST_OK);
            state      <= S_IDLE;
            if (item.last_of_site) begin
              // Closing the site: a new epoch empties the name set at once.
              names_held  <= '0;
              tally_a     <= '0;
              tally_b     <= '0;
              tally_other <= '0;
              if (epoch == '1) begin
                epoch   <= EPOCH_W'(1);
                clr_cnt <= '0;
                state   <= S_CLEAR;
              end else begin
                epoch <= epoch + 1'b1;
              end
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // The epoch tag zero marks freed slots and must never become current.
  a_epoch_nonzero: assert property (@(posedge clk) disable iff (rst) epoch != '0)
    else $error("current epoch is zero");

  // A new result is only ever loaded from the result state.
  a_load_from_post: assert property (@(posedge clk) disable iff (rst)
    (!out_valid ##1 out_valid) |-> $past(state == S_POST))
    else $error("result loaded outside the result state");

  // Reduction results only arrive where the sequencer waits for them.
  a_mod_done_expected: assert property (@(posedge clk) disable iff (rst)
    mod_done |-> (state == S_HOME || state == S_RMOD))
    else $error("unexpected key reduction result");

  // No input transaction is taken while the slot memory is being cleared.
  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !in_ready)
    else $error("input accepted during clearing pass");

endmodule

### sv/pacmd_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module pacmd_ram #(
  parameter int WIDTH = 72,
  parameter int DEPTH = 257
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/pacmd_mod.sv
// Multi-cycle unit that reduces a 64-bit key modulo a small modulus.
module pacmd_mod
  import pacmd_pkg::*;
#(
  parameter int REM_W = 9
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [KEY_W-1:0] key,
  input  logic [REM_W-1:0] modulus,
  output logic             done,
  output logic [REM_W-1:0] rem
);

  logic [KEY_W-1:0]     sh;
  logic [REM_W-1:0]     md;
  logic [MOD_CYC_W-1:0] cnt;
  logic                 busy;
  logic [REM_W-1:0]     rem_next;

  // Restoring reduction of eight key bits per cycle, most significant first.
  always_comb begin
    logic [REM_W:0] t;
    rem_next = rem;
    for (int i = 0; i < MOD_BITS; i++) begin
      t = {rem_next, sh[KEY_W-1-i]};
      if (t >= {1'b0, md}) begin
        t = t - {1'b0, md};
      end
      rem_next = t[REM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == '1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh  <= key;
      md  <= modulus;
      rem <= '0;
    end else if (busy) begin
      sh  <= sh << MOD_BITS;
      rem <= rem_next;
    end
  end

endmodule
